// ===== rtl/bfr_pkg.sv =====
// ----------------------------------------------------------------------------
// bfr_pkg: shared types and constants for the block frame receiver
// Frame phases, status codes, input kinds, CRC constants and the result record.
// ----------------------------------------------------------------------------
package bfr_pkg;

  localparam logic [7:0]  LEAD_BYTE     = 8'hA5;
  localparam logic [7:0]  BAD_BYTE      = 8'hFF;
  localparam logic [15:0] CRC_POLY      = 16'h8408;
  localparam logic [15:0] CRC_INIT      = 16'hFFFF;
  localparam logic [7:0]  RBLK_MASK     = 8'hE0;
  localparam logic [7:0]  RBLK_CODE     = 8'h80;
  localparam logic [7:0]  RBLK_ERR_MASK = 8'h03;
  localparam logic [15:0] TICKS_MAX     = 16'hFFFF;
  localparam logic [15:0] TIMEOUT_RST   = 16'd500;

  typedef enum logic [1:0] {
    KIND_BYTE  = 2'd0,
    KIND_TICK  = 2'd1,
    KIND_START = 2'd2,
    KIND_NONE  = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    PH_LEAD = 3'd0,
    PH_CTRL = 3'd1,
    PH_LEN  = 3'd2,
    PH_DATA = 3'd3,
    PH_CRCL = 3'd4,
    PH_CRCH = 3'd5
  } phase_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_BAD_LEAD = 3'd1,
    ST_BAD_CTRL = 3'd2,
    ST_BAD_LEN  = 3'd3,
    ST_CRC      = 3'd4,
    ST_PEER_ERR = 3'd5,
    ST_TIMEOUT  = 3'd6
  } status_t;

  typedef struct packed {
    logic       payload_valid;
    logic [7:0] payload_byte;
    logic       frame_done;
    status_t    status;
    logic [7:0] control_byte;
    logic [7:0] payload_length;
  } res_t;

endpackage

// ===== rtl/bfr_crc_byte.sv =====
// ----------------------------------------------------------------------------
// bfr_crc_byte: one-byte CRC-16/X.25 update
// Reflected polynomial, unrolled over the eight bits of one byte.
// ----------------------------------------------------------------------------
module bfr_crc_byte (
  input  logic [15:0] crc_in,
  input  logic [7:0]  data,
  output logic [15:0] crc_out
);

  always_comb begin
    logic [15:0] c;
    c = crc_in ^ {8'h00, data};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ bfr_pkg::CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    crc_out = c;
  end

endmodule

// ===== rtl/bfr_frame_fsm.sv =====
// ----------------------------------------------------------------------------
// bfr_frame_fsm: frame state and per-beat decision
// Holds the frame state, advances it by one beat and forms the result record.
// ----------------------------------------------------------------------------
module bfr_frame_fsm (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             step,
  input  bfr_pkg::kind_t   kind,
  input  logic [7:0]       rx_byte,
  input  logic [15:0]      timeout_ticks,
  output logic             res_valid,
  output bfr_pkg::res_t    res
);

  logic             armed_r, armed_nxt;
  bfr_pkg::phase_t  phase_r, phase_nxt;
  logic [7:0]       frame_len_r, frame_len_nxt;
  logic [7:0]       byte_count_r, byte_count_nxt;
  logic [15:0]      crc_r, crc_nxt;
  logic [7:0]       ctrl_r, ctrl_nxt;
  logic [7:0]       crc_low_r, crc_low_nxt;
  logic [15:0]      elapsed_r, elapsed_nxt;

  logic [15:0] crc_upd;
  logic [15:0] elapsed_inc;
  logic        tick_timeout;
  logic [15:0] crc_fin;
  logic        crc_ok;
  logic        peer_err;
  logic [7:0]  byte_count_inc;

  bfr_crc_byte u_crc (
    .crc_in  (crc_r),
    .data    (rx_byte),
    .crc_out (crc_upd)
  );

  assign elapsed_inc    = (elapsed_r == bfr_pkg::TICKS_MAX) ? elapsed_r : elapsed_r + 16'd1;
  assign tick_timeout   = (elapsed_inc >= timeout_ticks);
  assign crc_fin        = ~crc_r;
  assign crc_ok         = (crc_low_r == crc_fin[7:0]) && (rx_byte == crc_fin[15:8]);
  assign peer_err       = ((ctrl_r & bfr_pkg::RBLK_MASK) == bfr_pkg::RBLK_CODE) &&
                          ((ctrl_r & bfr_pkg::RBLK_ERR_MASK) != 8'h00);
  assign byte_count_inc = byte_count_r + 8'd1;

  // Next state.
  always_comb begin
    armed_nxt      = armed_r;
    phase_nxt      = phase_r;
    frame_len_nxt  = frame_len_r;
    byte_count_nxt = byte_count_r;
    crc_nxt        = crc_r;
    ctrl_nxt       = ctrl_r;
    crc_low_nxt    = crc_low_r;
    elapsed_nxt    = elapsed_r;
    if (step) begin
      case (kind)
        bfr_pkg::KIND_START: begin
          armed_nxt      = 1'b1;
          phase_nxt      = bfr_pkg::PH_LEAD;
          frame_len_nxt  = 8'h00;
          byte_count_nxt = 8'h00;
          crc_nxt        = bfr_pkg::CRC_INIT;
          ctrl_nxt       = 8'h00;
          crc_low_nxt    = 8'h00;
          elapsed_nxt    = 16'h0000;
        end
        bfr_pkg::KIND_TICK: begin
          if (armed_r) begin
            elapsed_nxt = elapsed_inc;
            if (tick_timeout) begin
              armed_nxt = 1'b0;
            end
          end
        end
        bfr_pkg::KIND_BYTE: begin
          if (armed_r) begin
            case (phase_r)
              bfr_pkg::PH_LEAD: begin
                if (rx_byte == 8'h00) begin
                  // A zero byte while hunting counts as a poll tick.
                  elapsed_nxt = elapsed_inc;
                  if (tick_timeout) begin
                    armed_nxt = 1'b0;
                  end
                end else if (rx_byte != bfr_pkg::LEAD_BYTE) begin
                  armed_nxt = 1'b0;
                end else begin
                  crc_nxt   = crc_upd;
                  phase_nxt = bfr_pkg::PH_CTRL;
                end
              end
              bfr_pkg::PH_CTRL: begin
                if (rx_byte == bfr_pkg::BAD_BYTE) begin
                  armed_nxt = 1'b0;
                end else begin
                  ctrl_nxt  = rx_byte;
                  crc_nxt   = crc_upd;
                  phase_nxt = bfr_pkg::PH_LEN;
                end
              end
              bfr_pkg::PH_LEN: begin
                if (rx_byte == bfr_pkg::BAD_BYTE) begin
                  armed_nxt = 1'b0;
                end else begin
                  frame_len_nxt  = rx_byte;
                  crc_nxt        = crc_upd;
                  byte_count_nxt = 8'h00;
                  phase_nxt      = (rx_byte == 8'h00) ? bfr_pkg::PH_CRCL : bfr_pkg::PH_DATA;
                end
              end
              bfr_pkg::PH_DATA: begin
                crc_nxt        = crc_upd;
                byte_count_nxt = byte_count_inc;
                if (byte_count_inc >= frame_len_r) begin
                  phase_nxt = bfr_pkg::PH_CRCL;
                end
              end
              bfr_pkg::PH_CRCL: begin
                crc_low_nxt = rx_byte;
                phase_nxt   = bfr_pkg::PH_CRCH;
              end
              bfr_pkg::PH_CRCH: begin
                armed_nxt = 1'b0;
              end
              default: begin
                armed_nxt = 1'b0;
              end
            endcase
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Result of the beat; control byte and length show the values held before it.
  always_comb begin
    res_valid          = 1'b0;
    res.payload_valid  = 1'b0;
    res.payload_byte   = 8'h00;
    res.frame_done     = 1'b0;
    res.status         = bfr_pkg::ST_OK;
    res.control_byte   = ctrl_r;
    res.payload_length = frame_len_r;
    if (armed_r) begin
      case (kind)
        bfr_pkg::KIND_TICK: begin
          if (tick_timeout) begin
            res_valid      = 1'b1;
            res.frame_done = 1'b1;
            res.status     = bfr_pkg::ST_TIMEOUT;
          end
        end
        bfr_pkg::KIND_BYTE: begin
          case (phase_r)
            bfr_pkg::PH_LEAD: begin
              if (rx_byte == 8'h00) begin
                if (tick_timeout) begin
                  res_valid      = 1'b1;
                  res.frame_done = 1'b1;
                  res.status     = bfr_pkg::ST_TIMEOUT;
                end
              end else if (rx_byte != bfr_pkg::LEAD_BYTE) begin
                res_valid      = 1'b1;
                res.frame_done = 1'b1;
                res.status     = bfr_pkg::ST_BAD_LEAD;
              end
            end
            bfr_pkg::PH_CTRL: begin
              if (rx_byte == bfr_pkg::BAD_BYTE) begin
                res_valid      = 1'b1;
                res.frame_done = 1'b1;
                res.status     = bfr_pkg::ST_BAD_CTRL;
              end
            end
            bfr_pkg::PH_LEN: begin
              if (rx_byte == bfr_pkg::BAD_BYTE) begin
                res_valid      = 1'b1;
                res.frame_done = 1'b1;
                res.status     = bfr_pkg::ST_BAD_LEN;
              end
            end
            bfr_pkg::PH_DATA: begin
              res_valid         = 1'b1;
              res.payload_valid = 1'b1;
              res.payload_byte  = rx_byte;
            end
            bfr_pkg::PH_CRCH: begin
              res_valid      = 1'b1;
              res.frame_done = 1'b1;
              if (!crc_ok) begin
                res.status = bfr_pkg::ST_CRC;
              end else if (peer_err) begin
                res.status = bfr_pkg::ST_PEER_ERR;
              end else begin
                res.status = bfr_pkg::ST_OK;
              end
            end
            default: begin
            end
          endcase
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      armed_r      <= 1'b0;
      phase_r      <= bfr_pkg::PH_LEAD;
      frame_len_r  <= 8'h00;
      byte_count_r <= 8'h00;
      crc_r        <= bfr_pkg::CRC_INIT;
      ctrl_r       <= 8'h00;
      crc_low_r    <= 8'h00;
      elapsed_r    <= 16'h0000;
    end else begin
      armed_r      <= armed_nxt;
      phase_r      <= phase_nxt;
      frame_len_r  <= frame_len_nxt;
      byte_count_r <= byte_count_nxt;
      crc_r        <= crc_nxt;
      ctrl_r       <= ctrl_nxt;
      crc_low_r    <= crc_low_nxt;
      elapsed_r    <= elapsed_nxt;
    end
  end

endmodule

// ===== rtl/block_frame_receiver_crc16_top.sv =====
// ----------------------------------------------------------------------------
// block_frame_receiver_crc16_top: block frame receiver with CRC-16/X.25 check
// Input beat register, frame state machine and result register.
// ----------------------------------------------------------------------------
// Order: a beat is held in the input register, and its result, if any, in the result register.
// Throughput: one beat per cycle; the input register takes a new beat
// whenever its current one moves on, which needs the result register free.
// Reset: rst_n (synchronous, active low) disarms the receiver, empties both
// registers and sets timeout_ticks to 500.
module block_frame_receiver_crc16_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_kind,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_payload_valid,
  output logic [7:0]  out_payload_byte,
  output logic        out_frame_done,
  output logic [2:0]  out_status,
  output logic [7:0]  out_control_byte,
  output logic [7:0]  out_payload_length,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data
);

  logic [15:0]    timeout_r;
  logic           item_vld_r;
  bfr_pkg::kind_t item_kind_r;
  logic [7:0]     item_byte_r;
  logic           out_vld_r;
  bfr_pkg::res_t  out_r;

  logic           proc_fire;
  logic           res_valid;
  bfr_pkg::res_t  res;

  assign proc_fire = item_vld_r && (!out_vld_r || out_ready);
  assign in_ready  = !item_vld_r || proc_fire;

  bfr_frame_fsm u_fsm (
    .clk           (clk),
    .rst_n         (rst_n),
    .step          (proc_fire),
    .kind          (item_kind_r),
    .rx_byte       (item_byte_r),
    .timeout_ticks (timeout_r),
    .res_valid     (res_valid),
    .res           (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r <= bfr_pkg::TIMEOUT_RST;
    end else if (cfg_wr_en) begin
      timeout_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_vld_r <= 1'b0;
    end else if (in_ready) begin
      item_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_kind_r <= bfr_pkg::kind_t'(in_kind);
      item_byte_r <= in_rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (proc_fire && res_valid) begin
      out_vld_r <= 1'b1;
    end else if (out_ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (proc_fire && res_valid) begin
      out_r <= res;
    end
  end

  assign out_valid          = out_vld_r;
  assign out_payload_valid  = out_r.payload_valid;
  assign out_payload_byte   = out_r.payload_byte;
  assign out_frame_done     = out_r.frame_done;
  assign out_status         = out_r.status;
  assign out_control_byte   = out_r.control_byte;
  assign out_payload_length = out_r.payload_length;

  // A held beat that cannot move on stays in the input register.
  a_item_held: assert property (@(posedge clk) disable iff (!rst_n)
    item_vld_r && !proc_fire |=> item_vld_r)
    else $error("input beat lost while stalled");

  // A result that is not taken is still there on the next cycle.
  a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && !out_ready |=> out_vld_r)
    else $error("result dropped before it was taken");

  a_done_no_payload: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && out_frame_done |-> !out_payload_valid)
    else $error("end of frame flagged together with a payload byte");

  a_status_only_at_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && !out_frame_done |-> out_status == bfr_pkg::ST_OK)
    else $error("nonzero status on a payload result");

endmodule

// ===== sim/block_frame_receiver_crc16_top_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// block_frame_receiver_crc16_top_tb: self-checking bench for the frame receiver
// Drives start, poll, byte and no-op beats with random idle and stall bursts, tracks
// the frame state and CRC-16/X.25 in the bench, and checks every result beat.
// ----------------------------------------------------------------------------
module block_frame_receiver_crc16_top_tb;
  import bfr_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;

  // Where the byte of a table row comes from: the literal or the running CRC.
  typedef enum logic [1:0] {
    SRC_LIT     = 2'd0,
    SRC_CRC_LO  = 2'd1,
    SRC_CRC_HI  = 2'd2,
    SRC_CRC_BAD = 2'd3
  } byte_src_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] lit;
    byte_src_t  src;
    logic       typed;
    res_t       res;
  } dir_row_t;

  localparam res_t NO_RES = '0;

  localparam dir_row_t DIR_ROWS [27] = '{
    '{KIND_TICK,  8'h00, SRC_LIT,     1'b0, NO_RES},
    '{KIND_START, 8'h00, SRC_LIT,     1'b0, NO_RES},
    '{KIND_BYTE,  8'h00, SRC_LIT,     1'b0, NO_RES},
    '{KIND_BYTE,  8'h12, SRC_LIT,     1'b1, '{1'b0, 8'h00, 1'b1, ST_BAD_LEAD, 8'h00, 8'h00}},
    '{KIND_START, 8'h00, SRC_LIT,     1'b0, NO_RES},
    '{KIND_BYTE,  8'hA5, SRC_LIT,     1'b0, NO_RES},
    '{KIND_BYTE,  8'hFF, SRC_LIT,     1'b1, '{1'b0, 8'h00, 1'b1, ST_BAD_CTRL, 8'h00, 8'h00}},
    '{KIND_START, 8'h00, SRC_LIT,     1'b0, NO_RES},
    '{KIND_BYTE,  8'hA5, SRC_LIT,     1'b0, NO_RES},
    '{KIND_BYTE,  8'h00, SRC_LIT,     1'b0, NO_RES},
    '{KIND_BYTE,  8'hFF, SRC_LIT,     1'b1, '{1'b0, 8'h00, 1'b1, ST_BAD_LEN, 8'h00, 8'h00}},
    '{KIND_START, 8'h00, SRC_LIT,     1'b0, NO_RES},
    '{KIND_BYTE,  8'hA5, SRC_LIT,     1'b0, NO_RES},
    '{KIND_START, 8'h00, SRC_LIT,     1'b0, NO_RES},
    '{KIND_BYTE,  8'hA5, SRC_LIT,     1'b0, NO_RES},
    '{KIND_BYTE,  8'h81, SRC_LIT,     1'b0, NO_RES},
    '{KIND_BYTE,  8'h01, SRC_LIT,     1'b0, NO_RES},
    '{KIND_BYTE,  8'hFF, SRC_LIT,     1'b0, NO_RES},
    '{KIND_NONE,  8'h55, SRC_LIT,     1'b0, NO_RES},
    '{KIND_BYTE,  8'h00, SRC_CRC_LO,  1'b0, NO_RES},
    '{KIND_BYTE,  8'h00, SRC_CRC_HI,  1'b0, NO_RES},
    '{KIND_START, 8'h00, SRC_LIT,     1'b0, NO_RES},
    '{KIND_BYTE,  8'hA5, SRC_LIT,     1'b0, NO_RES},
    '{KIND_BYTE,  8'h83, SRC_LIT,     1'b0, NO_RES},
    '{KIND_BYTE,  8'h00, SRC_LIT,     1'b0, NO_RES},
    '{KIND_BYTE,  8'h00, SRC_CRC_BAD, 1'b0, NO_RES},
    '{KIND_BYTE,  8'h00, SRC_CRC_HI,  1'b1, '{1'b0, 8'h00, 1'b1, ST_CRC, 8'h83, 8'h00}}
  };

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  in_kind;
  logic [7:0]  in_rx_byte;
  logic        out_valid;
  logic        out_ready;
  logic        out_payload_valid;
  logic [7:0]  out_payload_byte;
  logic        out_frame_done;
  logic [2:0]  out_status;
  logic [7:0]  out_control_byte;
  logic [7:0]  out_payload_length;
  logic        cfg_wr_en;
  logic [15:0] cfg_wr_data;

  // Receiver state as the bench expects it.
  logic        rx_armed;
  phase_t      rx_phase;
  logic [7:0]  rx_len;
  logic [7:0]  rx_count;
  logic [15:0] rx_crc;
  logic [7:0]  rx_ctrl;
  logic [7:0]  rx_crc_lo;
  logic [15:0] rx_ticks;
  logic [15:0] tmo_ticks;

  res_t        owed_results [$];
  res_t        want;
  int unsigned errors;
  int unsigned beats_sent;
  int unsigned cycle_cnt;
  bit          quiet;

  block_frame_receiver_crc16_top u_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_kind            (in_kind),
    .in_rx_byte         (in_rx_byte),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_payload_valid  (out_payload_valid),
    .out_payload_byte   (out_payload_byte),
    .out_frame_done     (out_frame_done),
    .out_status         (out_status),
    .out_control_byte   (out_control_byte),
    .out_payload_length (out_payload_length),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_wr_data        (cfg_wr_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic logic [15:0] crc_x25_step(input logic [15:0] c, input logic [7:0] b);
    logic [15:0] v;
    v = c ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      v = v[0] ? ((v >> 1) ^ CRC_POLY) : (v >> 1);
    end
    return v;
  endfunction

  // Applies one accepted beat to the tracked state and returns its result, if any.
  task automatic track_frame(input kind_t k, input logic [7:0] b, output bit got,
                             output res_t r);
    logic [15:0] fin;
    bit          ended;
    status_t     st;
    got   = 1'b0;
    ended = 1'b0;
    st    = ST_OK;
    r     = '0;
    fin   = ~rx_crc;
    if (k == KIND_START) begin
      rx_armed  = 1'b1;
      rx_phase  = PH_LEAD;
      rx_len    = 8'h00;
      rx_count  = 8'h00;
      rx_crc    = CRC_INIT;
      rx_ctrl   = 8'h00;
      rx_crc_lo = 8'h00;
      rx_ticks  = 16'h0000;
    end else if (k == KIND_NONE || !rx_armed) begin
      got = 1'b0;
    end else if (k == KIND_TICK || (rx_phase == PH_LEAD && b == 8'h00)) begin
      // A zero byte while hunting for the lead byte is a poll tick.
      if (rx_ticks != TICKS_MAX) rx_ticks = rx_ticks + 16'd1;
      if (rx_ticks >= tmo_ticks) begin
        ended = 1'b1;
        st    = ST_TIMEOUT;
      end
    end else begin
      case (rx_phase)
        PH_LEAD: begin
          if (b != LEAD_BYTE) begin
            ended = 1'b1;
            st    = ST_BAD_LEAD;
          end else begin
            rx_crc   = crc_x25_step(rx_crc, b);
            rx_phase = PH_CTRL;
          end
        end
        PH_CTRL: begin
          if (b == BAD_BYTE) begin
            ended = 1'b1;
            st    = ST_BAD_CTRL;
          end else begin
            rx_ctrl  = b;
            rx_crc   = crc_x25_step(rx_crc, b);
            rx_phase = PH_LEN;
          end
        end
        PH_LEN: begin
          if (b == BAD_BYTE) begin
            ended = 1'b1;
            st    = ST_BAD_LEN;
          end else begin
            rx_len   = b;
            rx_crc   = crc_x25_step(rx_crc, b);
            rx_count = 8'h00;
            rx_phase = (b == 8'h00) ? PH_CRCL : PH_DATA;
          end
        end
        PH_DATA: begin
          rx_crc   = crc_x25_step(rx_crc, b);
          rx_count = rx_count + 8'd1;
          if (rx_count >= rx_len) rx_phase = PH_CRCL;
          got             = 1'b1;
          r.payload_valid = 1'b1;
          r.payload_byte  = b;
        end
        PH_CRCL: begin
          rx_crc_lo = b;
          rx_phase  = PH_CRCH;
        end
        PH_CRCH: begin
          // The CRC is judged before the R-block error bits are looked at.
          ended = 1'b1;
          if (rx_crc_lo != fin[7:0] || b != fin[15:8]) begin
            st = ST_CRC;
          end else if ((rx_ctrl & RBLK_MASK) == RBLK_CODE &&
                       (rx_ctrl & RBLK_ERR_MASK) != 8'h00) begin
            st = ST_PEER_ERR;
          end else begin
            st = ST_OK;
          end
        end
        default: begin
          rx_armed = 1'b0;
        end
      endcase
    end
    if (ended) begin
      rx_armed     = 1'b0;
      got          = 1'b1;
      r.frame_done = 1'b1;
      r.status     = st;
    end
    r.control_byte   = rx_ctrl;
    r.payload_length = rx_len;
  endtask

  function automatic logic [7:0] crc_byte_for(input byte_src_t src, input logic [7:0] lit);
    logic [15:0] fin;
    fin = ~rx_crc;
    case (src)
      SRC_CRC_LO:  return fin[7:0];
      SRC_CRC_HI:  return fin[15:8];
      SRC_CRC_BAD: return fin[7:0] ^ 8'h01;
      default:     return lit;
    endcase
  endfunction

  // Called at a falling edge; returns at a falling edge with valid still high
  // unless an idle burst was taken.
  task automatic send_beat(input kind_t k, input logic [7:0] b, input bit typed,
                           input res_t typed_res);
    bit   got;
    res_t r;
    in_valid   = 1'b1;
    in_kind    = k;
    in_rx_byte = b;
    do @(posedge clk); while (!in_ready);
    track_frame(k, b, got, r);
    if (got) owed_results.push_back(typed ? typed_res : r);
    beats_sent++;
    @(negedge clk);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk);
    end
  endtask

  task automatic send_byte(input logic [7:0] b);
    send_beat(KIND_BYTE, b, 1'b0, NO_RES);
  endtask

  task automatic write_timeout(input logic [15:0] v);
    in_valid = 1'b0;
    while (owed_results.size() != 0) @(posedge clk);
    // A beat with no result may still sit in the pipeline.
    repeat (6) @(posedge clk);
    @(negedge clk);
    cfg_wr_en   = 1'b1;
    cfg_wr_data = v;
    @(negedge clk);
    cfg_wr_en = 1'b0;
    tmo_ticks = v;
  endtask

  // One random frame, mostly well formed; some are noise or cut short.
  task automatic send_random_frame(input bit long_frame);
    logic [7:0] ctrl;
    logic [7:0] len;
    logic [7:0] lo;
    logic [7:0] hi;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 8) begin
      repeat ($urandom_range(1, 4)) begin
        send_beat(kind_t'(2'($urandom_range(0, 3))), 8'($urandom), 1'b0, NO_RES);
      end
      return;
    end
    if (pick >= 13 || long_frame) send_beat(KIND_START, 8'($urandom), 1'b0, NO_RES);
    repeat ($urandom_range(0, 2)) begin
      if ($urandom_range(0, 1) == 0) send_beat(KIND_TICK, 8'($urandom), 1'b0, NO_RES);
      else send_byte(8'h00);
    end
    if (!rx_armed) return;
    send_byte(($urandom_range(0, 19) == 0) ? 8'($urandom) : LEAD_BYTE);
    if (!rx_armed) return;
    case ($urandom_range(0, 19))
      0:       ctrl = BAD_BYTE;
      1, 2, 3: ctrl = RBLK_CODE | 8'($urandom_range(0, 31));
      default: ctrl = 8'($urandom);
    endcase
    send_byte(ctrl);
    if (!rx_armed) return;
    pick = $urandom_range(0, 99);
    if (long_frame || pick == 2) len = 8'd254;
    else if (pick < 2) len = BAD_BYTE;
    else len = 8'($urandom_range(0, 6));
    send_byte(len);
    if (!rx_armed) return;
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 49) == 0) begin
        send_beat(KIND_START, 8'($urandom), 1'b0, NO_RES);
        return;
      end
      if ($urandom_range(0, 11) == 0) send_beat(KIND_TICK, 8'($urandom), 1'b0, NO_RES);
      if (!rx_armed) return;
      send_byte(8'($urandom));
    end
    lo = crc_byte_for(SRC_CRC_LO, 8'h00);
    if ($urandom_range(0, 9) == 0) lo = lo ^ (8'h01 << $urandom_range(0, 7));
    send_byte(lo);
    if (!rx_armed) return;
    hi = crc_byte_for(SRC_CRC_HI, 8'h00);
    if ($urandom_range(0, 19) == 0) hi = hi ^ (8'h01 << $urandom_range(0, 7));
    send_byte(hi);
  endtask

  task automatic check_field(input string name, input int unsigned exp_v,
                             input int unsigned act_v);
    if (exp_v != act_v) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (owed_results.size() == 0) begin
        $display("%0t: result beat with none expected, actual status %0d payload %0h",
                 $time, out_status, out_payload_byte);
        errors++;
      end else begin
        want = owed_results.pop_front();
        check_field("payload_valid", 32'(want.payload_valid), 32'(out_payload_valid));
        check_field("payload_byte", 32'(want.payload_byte), 32'(out_payload_byte));
        check_field("frame_done", 32'(want.frame_done), 32'(out_frame_done));
        check_field("status", 32'(want.status), 32'(out_status));
        check_field("control_byte", 32'(want.control_byte), 32'(out_control_byte));
        check_field("payload_length", 32'(want.payload_length), 32'(out_payload_length));
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time, owed_results.size());
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    out_ready = 1'b1;
    forever begin
      @(negedge clk);
      if (!quiet && $urandom_range(0, 7) == 0) begin
        out_ready = 1'b0;
        repeat ($urandom_range(1, 5)) @(negedge clk);
      end
      out_ready = 1'b1;
    end
  end

  initial begin
    logic [15:0] tmo_plan [8];
    logic [15:0] tmo_val;
    int unsigned target;
    tmo_plan    = '{16'd1, 16'd65535, 16'd0, 16'd2, 16'd40, 16'd0, 16'd7, 16'd65535};
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_kind     = KIND_NONE;
    in_rx_byte  = 8'h00;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = 16'h0000;
    quiet       = 1'b0;
    errors      = 0;
    beats_sent  = 0;
    cycle_cnt   = 0;
    rx_armed    = 1'b0;
    rx_phase    = PH_LEAD;
    rx_len      = 8'h00;
    rx_count    = 8'h00;
    rx_crc      = CRC_INIT;
    rx_ctrl     = 8'h00;
    rx_crc_lo   = 8'h00;
    rx_ticks    = 16'h0000;
    tmo_ticks   = TIMEOUT_RST;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (DIR_ROWS[i]) begin
      send_beat(DIR_ROWS[i].kind, crc_byte_for(DIR_ROWS[i].src, DIR_ROWS[i].lit),
                DIR_ROWS[i].typed, DIR_ROWS[i].res);
    end

    for (int p = 0; p < 8; p++) begin
      tmo_val = (p == 5) ? 16'($urandom_range(3, 1000)) : tmo_plan[p];
      write_timeout(tmo_val);
      quiet  = (p == 7);
      target = beats_sent + 103;
      // One frame of the longest legal length while timeouts are out of reach.
      if (p == 1) send_random_frame(1'b1);
      while (beats_sent < target) send_random_frame(1'b0);
    end

    in_valid = 1'b0;
    while (owed_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
